>>> rtl/core/lkc_pkg.sv
// Shared definitions for the LRU key cache: default sizes, operation codes
// and the status struct passed from the directory to the top level.
// No dependencies.
package lkc_pkg;

   // default geometry, handed to the top level parameters
   localparam int ENTRIES_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int VALUE_BITS_DEFAULT = 32;

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int CAP_W   = 5;
   localparam int COUNT_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // operation codes; the fourth code is unused and changes nothing
   localparam logic [OP_W-1:0] OP_GET    = 2'd0;
   localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // per-operation status from the directory
   typedef struct packed {
      logic hit;      // key was live before the operation
      logic evicted;  // a put pushed out the least recent entry
      logic get_hit;  // value store read returns the result value
      logic ins_en;   // value store write for a newly inserted key
   } dir_flags_type;

endpackage

>>> rtl/core/lkc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lkc_dir.sv
// Directory of the LRU key cache: key tags, valid bits, recency ranks and
// live count, with the parallel key match and the rank update.
// Depends on lkc_pkg.
module lkc_dir #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          op_valid,
   input  logic [lkc_pkg::OP_W-1:0]      op,
   input  logic [KEY_BITS-1:0]           key,
   input  logic [lkc_pkg::CAP_W-1:0]     capacity,
   output lkc_pkg::dir_flags_type        flags,
   output logic [KEY_BITS-1:0]           evicted_key,
   output logic [$clog2(ENTRIES+1)-1:0]  entry_count,
   output logic [$clog2(ENTRIES)-1:0]    rd_slot,
   output logic [$clog2(ENTRIES)-1:0]    ins_slot
);
   import lkc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

   // state
   logic [KEY_BITS-1:0] key_ff   [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [IDX_W-1:0]    rank_ff  [ENTRIES];
   logic [IDX_W-1:0]    rank_in  [ENTRIES];
   logic [CNT_W-1:0]    count_ff, count_in;

   // match and selection
   logic [ENTRIES-1:0]  match, match_one, victim, victim_one, ev_one;
   logic [ENTRIES-1:0]  valid_mid, free_one;
   logic                hit, evicted, ins;
   logic [IDX_W-1:0]    hit_rank, ev_rank, hit_idx, free_idx, r_tmp;
   logic [KEY_BITS-1:0] ev_key;
   logic [CMP_W-1:0]    cap_ext, cap_eff, count_ext;
   logic                is_get, is_put, is_del;
   logic                cap_on, need_evict, do_touch, do_insert, do_del;

   // operation decode
   always_comb begin
      is_get = 1'b0;
      is_put = 1'b0;
      is_del = 1'b0;
      unique case (op)
         OP_GET:    is_get = 1'b1;
         OP_PUT:    is_put = 1'b1;
         OP_DELETE: is_del = 1'b1;
         default:   ;
      endcase
   end

   // parallel key compare, victim search and free-slot search
   always_comb begin
      cap_ext    = CMP_W'(capacity);
      cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
      count_ext  = CMP_W'(count_ff);
      cap_on     = (cap_eff != '0);
      need_evict = (count_ext + CMP_W'(1)) > cap_eff;

      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == key);
         victim[i] = valid_ff[i] &&
                     ((CMP_W'(rank_ff[i]) + CMP_W'(1)) == count_ext);
      end
      match_one  = match & (~match + ENTRIES'(1));
      victim_one = victim & (~victim + ENTRIES'(1));
      hit        = |match;

      do_touch  = hit && (is_get || (is_put && cap_on));
      do_insert = is_put && cap_on && !hit;
      do_del    = is_del && hit;

      ev_one    = (do_insert && need_evict) ? victim_one : '0;
      evicted   = |ev_one;
      valid_mid = valid_ff & ~ev_one;
      free_one  = ~valid_mid & (valid_mid + ENTRIES'(1));
      ins       = do_insert && (valid_mid != '1);

      hit_rank = '0;
      hit_idx  = '0;
      ev_rank  = '0;
      ev_key   = '0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_one[i]) begin
            hit_rank = hit_rank | rank_ff[i];
            hit_idx  = hit_idx | IDX_W'(i);
         end
         if (ev_one[i]) begin
            ev_rank = ev_rank | rank_ff[i];
            ev_key  = ev_key | key_ff[i];
         end
         if (free_one[i]) begin
            free_idx = free_idx | IDX_W'(i);
         end
      end
   end

   // next state for valid bits, ranks and count
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      r_tmp    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (do_touch) begin
         // move to front: more recent entries age by one
         for (int i = 0; i < ENTRIES; i++) begin
            if (match_one[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
      end else if (do_del) begin
         // remove: less recent entries move up by one
         for (int i = 0; i < ENTRIES; i++) begin
            if (match_one[i]) begin
               valid_in[i] = 1'b0;
               rank_in[i]  = '0;
            end else if (valid_ff[i] && (rank_ff[i] > hit_rank)) begin
               rank_in[i] = rank_ff[i] - IDX_W'(1);
            end
         end
         count_in = count_ff - CNT_W'(1);
      end else if (do_insert) begin
         // optional eviction, then insert at the front
         for (int i = 0; i < ENTRIES; i++) begin
            r_tmp = rank_ff[i];
            if (evicted && (rank_ff[i] > ev_rank)) begin
               r_tmp = r_tmp - IDX_W'(1);
            end
            if (ins) begin
               r_tmp = r_tmp + IDX_W'(1);
            end
            if (ev_one[i]) begin
               valid_in[i] = 1'b0;
               rank_in[i]  = '0;
            end else if (valid_mid[i]) begin
               rank_in[i] = r_tmp;
            end
            if (ins && free_one[i]) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end
         end
         count_in = count_ff - CNT_W'(evicted) + CNT_W'(ins);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (op_valid) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // key tags
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (op_valid && ins && free_one[i]) begin
            key_ff[i] <= key;
         end
      end
   end

   assign flags.hit     = hit;
   assign flags.evicted = evicted;
   assign flags.get_hit = is_get && hit;
   assign flags.ins_en  = op_valid && ins;
   assign evicted_key   = ev_key;
   assign entry_count   = count_in;
   assign rd_slot       = hit_idx;
   assign ins_slot      = free_idx;

endmodule

>>> rtl/core/lru_key_cache.sv
// Top level of the LRU key cache: input register, directory, value store
// and result register. Depends on lkc_pkg, lkc_dir and lkc_ram.
//
// Usage:
//   Command channel: an operation (req_op get/put/delete, req_key,
//   req_value_in) is transferred on a clock edge with start high and busy
//   low. busy is always low: one operation can be issued every cycle.
//   Result channel: after the input and result registers, rsp_strobe is
//   high for exactly one cycle with rsp_hit, rsp_value_out, rsp_evicted,
//   rsp_evicted_key and rsp_entry_count. Results come back in issue order.
//   The receiver cannot stall; results must be taken when strobed.
//   Throughput is one operation per cycle: the whole key match and recency
//   update of the directory is done between the input register and the
//   result register.
//   Configuration: csr_wr_en with csr_wr_data writes the capacity; write
//   it only while no operation is in flight.
//   Reset (synchronous, active high) empties the cache and sets the
//   capacity to 16. No clearing pass is needed.
module lru_key_cache #(
   parameter int ENTRIES    = lkc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS   = lkc_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lkc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [lkc_pkg::OP_W-1:0]     req_op,
   input  logic [KEY_BITS-1:0]          req_key,
   input  logic [VALUE_BITS-1:0]        req_value_in,
   input  logic                         csr_wr_en,
   input  logic [lkc_pkg::CAP_W-1:0]    csr_wr_data,
   output logic                         rsp_strobe,
   output logic                         rsp_hit,
   output logic [VALUE_BITS-1:0]        rsp_value_out,
   output logic                         rsp_evicted,
   output logic [KEY_BITS-1:0]          rsp_evicted_key,
   output logic [lkc_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import lkc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic                  req_valid_ff;
   logic [OP_W-1:0]       req_op_ff;
   logic [KEY_BITS-1:0]   req_key_ff;
   logic [VALUE_BITS-1:0] req_value_ff;
   logic [CAP_W-1:0]      capacity_ff;

   dir_flags_type         flags;
   logic [KEY_BITS-1:0]   dir_ev_key;
   logic [CNT_W-1:0]      dir_count;
   logic [IDX_W-1:0]      rd_slot, ins_slot;
   logic [VALUE_BITS-1:0] ram_rd_data;

   logic                  rsp_valid_ff, hit_ff, evicted_ff, get_hit_ff;
   logic [KEY_BITS-1:0]   ev_key_ff;
   logic [COUNT_W-1:0]    count_ff;

   assign busy = 1'b0;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_op_ff    <= req_op;
         req_key_ff   <= req_key;
         req_value_ff <= req_value_in;
      end
   end

   // tag directory and recency state
   lkc_dir #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dir (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (req_valid_ff),
      .op          (req_op_ff),
      .key         (req_key_ff),
      .capacity    (capacity_ff),
      .flags       (flags),
      .evicted_key (dir_ev_key),
      .entry_count (dir_count),
      .rd_slot     (rd_slot),
      .ins_slot    (ins_slot)
   );

   // value store, read lines up with the result register
   lkc_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (flags.ins_en),
      .wr_addr (ins_slot),
      .wr_data (req_value_ff),
      .rd_en   (req_valid_ff),
      .rd_addr (rd_slot),
      .rd_data (ram_rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         hit_ff     <= flags.hit;
         evicted_ff <= flags.evicted;
         get_hit_ff <= flags.get_hit;
         ev_key_ff  <= dir_ev_key;
         count_ff   <= COUNT_W'(dir_count);
      end
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_value_out   = get_hit_ff ? ram_rd_data : '0;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = ev_key_ff;
   assign rsp_entry_count = count_ff;

`ifndef SYNTHESIS
   // every transfer produces a strobe after the input and result registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_strobe)
      else $error("result strobe missing after command transfer");

   // an eviction only happens on a put of an absent key
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_evicted |-> !rsp_hit)
      else $error("eviction reported on a hit");

   // a nonzero value is only returned on a hit
   a_value_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_value_out != '0) |-> rsp_hit)
      else $error("value returned without a hit");
`endif

endmodule
